// File: hdl/vtss_pkg.sv
package vtss_pkg;

    localparam int SIZE_W = 9;
    localparam logic [29:0] RECIP_M = 30'd572662307;
    localparam logic [27:0] Q_OFFSET = 28'd251658240;

    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;

    typedef logic signed [18:0] t_weight;
    typedef t_weight t_wvec [4];

    typedef struct packed {
        logic signed [5:0] ca;
        logic signed [5:0] cb;
        logic signed [5:0] cc;
    } t_coef;

    function automatic t_coef coef(input logic [1:0] t);
        t_coef c;
        unique case (t)
            2'd0: c = '{ca: -6'sd7, cb: 6'sd12, cc: -6'sd5};
            2'd1: c = '{ca: 6'sd12, cb: 6'sd18, cc: -6'sd15};
            2'd2: c = '{ca: -6'sd2, cb: -6'sd3, cc: 6'sd5};
            default: c = '{ca: 6'sd0, cb: 6'sd0, cc: 6'sd0};
        endcase
        return c;
    endfunction

endpackage

// File: hdl/volume_tricubic_spline_sampler.sv
// load transfer: one write into the volume memory (address below DEPTH), no result
// sample transfer: result set by the 64 reads of the single-port volume memory (one z
//   column at a time), the shared weight unit (one axis at a time) and the split
//   low/high y/x multiply steps; an out-of-range sample gives a flagged zero result
// a new input is taken only after the result is loaded into the output register
// sync active-low reset clears control, sets sizes to 64; volume memory is not cleared
module volume_tricubic_spline_sampler #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [6:0]   i_cfg_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // voxel_address, voxel_value, pos_x, pos_y, pos_z, zero pad
    input  logic [103:0] i_s_tdata,
    // mode
    input  logic         i_s_tuser,
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // sample_value, zero pad
    output logic [31:0]  o_m_tdata,
    // out_of_range
    output logic         o_m_tuser,
    output logic         o_m_tlast
);

    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = ((AW > 18) ? AW : 18) + 1;
    localparam int SW    = vtss_pkg::SIZE_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_G0   = 4'd1;
    localparam logic [3:0] ST_G1   = 4'd2;
    localparam logic [3:0] ST_G2   = 4'd3;
    localparam logic [3:0] ST_WGT  = 4'd4;
    localparam logic [3:0] ST_RD   = 4'd5;
    localparam logic [3:0] ST_RDW  = 4'd6;
    localparam logic [3:0] ST_Y0   = 4'd7;
    localparam logic [3:0] ST_Y1   = 4'd8;
    localparam logic [3:0] ST_X0   = 4'd9;
    localparam logic [3:0] ST_X1   = 4'd10;
    localparam logic [3:0] ST_X2   = 4'd11;
    localparam logic [3:0] ST_FIN  = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    logic [3:0]  r_state;
    logic [6:0]  r_size_x, r_size_y, r_size_z;
    logic [15:0] r_fx, r_fy, r_fz;
    logic        r_last;
    logic [6:0]  r_x0, r_y0, r_z0;
    logic [17:0] r_sxy;
    logic [16:0] r_ty;
    logic [25:0] r_tz;
    logic [AW-1:0] r_addr, r_addr_i, r_addr_ij;
    logic [1:0]  r_axis;
    logic        r_wstart;
    vtss_pkg::t_wvec r_wx, r_wy, r_wz;
    logic [1:0]  r_i, r_j, r_k;
    logic signed [35:0] r_accz;
    logic signed [37:0] r_plo;
    logic signed [55:0] r_accy, r_accx;
    logic signed [36:0] r_rnd;
    logic [25:0] r_res;
    logic        r_roor;
    logic        r_ovalid;
    logic [25:0] r_oval;
    logic        r_oor, r_olast;

    logic [SW-1:0] sx, sy, sz;
    logic [6:0]  ipx, ipy, ipz;
    logic        in_ok;
    logic        s_acc;
    logic [EW-1:0] load_addr;
    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0] ram_rdata;
    logic [15:0] wfrac;
    logic        wdone;
    vtss_pkg::t_wvec wvec;
    vtss_pkg::t_weight wz_sel, mw;
    logic signed [35:0] zp;
    logic signed [36:0] op;
    logic signed [37:0] plo_n, phi;
    logic signed [55:0] term;
    logic signed [55:0] rs;
    logic        out_load;

    assign sx = (SW'(r_size_x) > SW'(MAX_X)) ? SW'(MAX_X) : SW'(r_size_x);
    assign sy = (SW'(r_size_y) > SW'(MAX_Y)) ? SW'(MAX_Y) : SW'(r_size_y);
    assign sz = (SW'(r_size_z) > SW'(MAX_Z)) ? SW'(MAX_Z) : SW'(r_size_z);

    assign ipx = i_s_tdata[56:50];
    assign ipy = i_s_tdata[79:73];
    assign ipz = i_s_tdata[102:96];
    assign in_ok = (ipx >= 7'd2) && (SW'(ipx) + SW'(2) <= sx)
                && (ipy >= 7'd2) && (SW'(ipy) + SW'(2) <= sy)
                && (ipz >= 7'd2) && (SW'(ipz) + SW'(2) <= sz);

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign load_addr   = EW'(i_s_tdata[17:0]);
    assign ram_we      = s_acc && !i_s_tuser && (load_addr < EW'(DEPTH));
    assign ram_addr    = (r_state == ST_IDLE) ? load_addr[AW-1:0] : r_addr;

    vtss_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_s_tdata[33:18]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        unique case (r_axis)
            2'd0:    wfrac = r_fx;
            2'd1:    wfrac = r_fy;
            default: wfrac = r_fz;
        endcase
    end

    vtss_weight u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_wstart),
        .i_frac  (wfrac),
        .o_done  (wdone),
        .o_w     (wvec)
    );

    always_comb begin
        wz_sel = r_wz[r_k - 2'd1];
        zp     = wz_sel * $signed({1'b0, ram_rdata});
        if (r_state == ST_Y0 || r_state == ST_Y1) begin
            op = 37'(r_accz);
            mw = r_wy[r_j];
        end else begin
            op = r_rnd;
            mw = r_wx[r_i];
        end
        plo_n = mw * $signed({1'b0, op[17:0]});
        phi   = mw * $signed(op[36:18]);
        term  = (56'(phi) <<< 18) + 56'(r_plo);
        rs    = (r_accx + 56'sd33554432) >>> 26;
    end

    assign out_load = (r_state == ST_OUT) && (!r_ovalid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_size_x <= 7'd64;
            r_size_y <= 7'd64;
            r_size_z <= 7'd64;
            r_wstart <= 1'b0;
            r_ovalid <= 1'b0;
            r_axis   <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
        end else begin
            r_wstart <= (r_state == ST_G2)
                     || (r_state == ST_WGT && wdone && r_axis != 2'd2);
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    vtss_pkg::CFG_SIZE_X: r_size_x <= i_cfg_data;
                    vtss_pkg::CFG_SIZE_Y: r_size_y <= i_cfg_data;
                    vtss_pkg::CFG_SIZE_Z: r_size_z <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
                r_oval   <= r_res;
                r_oor    <= r_roor;
                r_olast  <= r_last;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_acc && i_s_tuser) begin
                        r_fx   <= i_s_tdata[49:34];
                        r_fy   <= i_s_tdata[72:57];
                        r_fz   <= i_s_tdata[95:80];
                        r_last <= i_s_tlast;
                        r_x0   <= ipx - 7'd2;
                        r_y0   <= ipy - 7'd2;
                        r_z0   <= ipz - 7'd2;
                        if (in_ok) begin
                            r_state <= ST_G0;
                        end else begin
                            r_res   <= '0;
                            r_roor  <= 1'b1;
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_G0: begin
                    r_sxy   <= 18'(sx) * 18'(sy);
                    r_ty    <= 17'(r_y0) * 17'(sx);
                    r_state <= ST_G1;
                end
                ST_G1: begin
                    r_tz    <= 26'(r_z0) * 26'(r_sxy);
                    r_state <= ST_G2;
                end
                ST_G2: begin
                    r_addr    <= AW'(26'(r_x0) + 26'(r_ty) + r_tz);
                    r_addr_i  <= AW'(26'(r_x0) + 26'(r_ty) + r_tz);
                    r_addr_ij <= AW'(26'(r_x0) + 26'(r_ty) + r_tz);
                    r_axis    <= 2'd0;
                    r_state   <= ST_WGT;
                end
                ST_WGT: begin
                    if (wdone) begin
                        unique case (r_axis)
                            2'd0:    r_wx <= wvec;
                            2'd1:    r_wy <= wvec;
                            default: r_wz <= wvec;
                        endcase
                        if (r_axis == 2'd2) begin
                            r_i     <= '0;
                            r_j     <= '0;
                            r_k     <= '0;
                            r_state <= ST_RD;
                        end else begin
                            r_axis   <= r_axis + 2'd1;
                        end
                    end
                end
                ST_RD: begin
                    r_accz <= (r_k == 2'd0) ? 36'sd0 : r_accz + zp;
                    r_addr <= r_addr + AW'(r_sxy);
                    r_k    <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= ST_RDW;
                    end
                end
                ST_RDW: begin
                    r_accz  <= r_accz + zp;
                    r_state <= ST_Y0;
                end
                ST_Y0: begin
                    r_plo   <= plo_n;
                    r_state <= ST_Y1;
                end
                ST_Y1: begin
                    r_accy <= ((r_j == 2'd0) ? 56'sd0 : r_accy) + term;
                    if (r_j == 2'd3) begin
                        r_state <= ST_X0;
                    end else begin
                        r_j       <= r_j + 2'd1;
                        r_addr_ij <= r_addr_ij + AW'(sx);
                        r_addr    <= r_addr_ij + AW'(sx);
                        r_state   <= ST_RD;
                    end
                end
                ST_X0: begin
                    r_rnd   <= 37'((r_accy + 56'sd65536) >>> 17);
                    r_state <= ST_X1;
                end
                ST_X1: begin
                    r_plo   <= plo_n;
                    r_state <= ST_X2;
                end
                ST_X2: begin
                    r_accx <= ((r_i == 2'd0) ? 56'sd0 : r_accx) + term;
                    if (r_i == 2'd3) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_i       <= r_i + 2'd1;
                        r_j       <= '0;
                        r_addr_i  <= r_addr_i + AW'(1);
                        r_addr_ij <= r_addr_i + AW'(1);
                        r_addr    <= r_addr_i + AW'(1);
                        r_state   <= ST_RD;
                    end
                end
                ST_FIN: begin
                    if (rs > 56'sd33554431) begin
                        r_res <= 26'h1FFFFFF;
                    end else if (rs < -56'sd33554432) begin
                        r_res <= 26'h2000000;
                    end else begin
                        r_res <= rs[25:0];
                    end
                    r_roor  <= 1'b0;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'b0, r_oval};
    assign o_m_tuser  = r_oor;
    assign o_m_tlast  = r_olast;

    a_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_state == ST_IDLE)
        else $error("volume write outside idle");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tdata == 32'd0)
        else $error("flagged result carries a value");

    a_wdone_wgt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wdone |-> r_state == ST_WGT)
        else $error("weight unit finished outside weight phase");

endmodule

// File: hdl/vtss_ram.sv
module vtss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 262144
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/vtss_weight.sv
module vtss_weight (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [15:0]       i_frac,
    output logic              o_done,
    output vtss_pkg::t_wvec   o_w
);

    localparam logic [3:0] STEP_LAST = 4'd9;

    logic [3:0]  r_step;
    logic [1:0]  r_t;
    logic [15:0] r_f;
    logic [31:0] r_f2;
    logic [47:0] r_f3;
    logic [27:0] r_x;
    vtss_pkg::t_weight r_wt [3];

    vtss_pkg::t_coef    c;
    logic signed [56:0] la, lb, lc, n, m;
    logic signed [25:0] q;
    logic [27:0]        x;
    logic [57:0]        pr;
    logic [24:0]        wd;

    always_comb begin
        c  = vtss_pkg::coef(r_t);
        la = $signed({9'b0, r_f, 32'b0});
        lb = $signed({9'b0, r_f2, 16'b0});
        lc = $signed({9'b0, r_f3});
        n  = la * 57'(c.ca) + lb * 57'(c.cb) + lc * 57'(c.cc);
        m  = n + 57'sd16106127360;
        q  = 26'(m >>> 31);
        x  = 28'(28'(q) + vtss_pkg::Q_OFFSET);
        pr = 58'(r_x) * 58'(vtss_pkg::RECIP_M);
        wd = pr[57:33] - 25'd16777216;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_t    <= '0;
        end else if (i_start) begin
            r_f    <= i_frac;
            r_t    <= '0;
            r_step <= 4'd1;
        end else if (r_step != 4'd0) begin
            r_step <= (r_step == STEP_LAST) ? 4'd0 : r_step + 4'd1;
            if (r_step == 4'd1) begin
                r_f2 <= 32'(r_f) * 32'(r_f);
            end else if (r_step == 4'd2) begin
                r_f3 <= 48'(r_f2) * 48'(r_f);
            end else if (r_step != STEP_LAST) begin
                if (r_step[0]) begin
                    r_x <= x;
                end else begin
                    r_wt[r_t] <= $signed(wd[18:0]);
                    r_t       <= r_t + 2'd1;
                end
            end
        end
    end

    assign o_done = (r_step == STEP_LAST);
    assign o_w[0] = r_wt[0];
    assign o_w[2] = r_wt[1];
    assign o_w[3] = r_wt[2];
    assign o_w[1] = 19'sd131072 - r_wt[0] - r_wt[1] - r_wt[2];

endmodule
